@@ hw/rtl/wstd_pkg.sv @@
// Shared types and codes for the work-stealing task dispatcher.
package wstd_pkg;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] SRC_OWN   = 2'd0;
    localparam logic [1:0] SRC_POOL  = 2'd1;
    localparam logic [1:0] SRC_STEAL = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic decide;     // evaluate item, update state, issue memory op
        logic scan_step;  // examine next steal candidate
        logic finish;     // latch read data into result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;  // request missed own deque and pool
        logic scan_done;  // scan found a victim or ran out
    } t_stat;
endpackage

@@ hw/rtl/wstd_ctrl.sv @@
// Controller state machine of the task dispatcher.
module wstd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  wstd_pkg::t_stat i_stat,
    output wstd_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = i_stat.need_scan ? S_SCAN : S_RD;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

@@ hw/rtl/wstd_dp.sv @@
// Datapath of the task dispatcher: deque and pool memories, pointers, result.
module wstd_dp #(
    parameter int NUM_WORKERS = 8,
    parameter int DEQUE_DEPTH = 16,
    parameter int POOL_DEPTH  = 32,
    parameter int TASK_BITS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wstd_pkg::t_cmd  i_cmd,
    output wstd_pkg::t_stat o_stat,
    input  logic            i_kind,
    input  logic [2:0]      i_worker,
    input  logic            i_from_worker,
    input  logic [15:0]     i_task_id,
    output logic [1:0]      o_status,
    output logic [15:0]     o_granted_task,
    output logic [1:0]      o_source,
    output logic [2:0]      o_victim
);
    localparam int WB = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int DB = $clog2(DEQUE_DEPTH);
    localparam int PB = $clog2(POOL_DEPTH);
    localparam int DCB = $clog2(DEQUE_DEPTH + 1);
    localparam int PCB = $clog2(POOL_DEPTH + 1);
    localparam int IB = $clog2(NUM_WORKERS + 1);
    localparam int XB = (IB > 3) ? IB : 3;
    localparam int NW_M1 = NUM_WORKERS - 1;
    localparam int DD_M1 = DEQUE_DEPTH - 1;
    localparam int PD_M1 = POOL_DEPTH - 1;

    // each worker owns a power-of-two block so the address is {worker, slot}
    logic [TASK_BITS-1:0] r_dq_mem [NUM_WORKERS*(1 << DB)];
    logic [TASK_BITS-1:0] r_pool_mem [POOL_DEPTH];
    logic [DB-1:0]  r_head [NUM_WORKERS];
    logic [DCB-1:0] r_cnt  [NUM_WORKERS];
    logic [PB-1:0]  r_phead;
    logic [PCB-1:0] r_pcnt;

    logic           r_kind, r_from;
    logic [2:0]     r_worker;
    logic [TASK_BITS-1:0] r_task;
    logic [1:0]     r_status, r_source;
    logic [2:0]     r_victim;
    logic           r_rd_dq, r_rd_pool;
    logic [TASK_BITS-1:0] r_dq_q, r_pool_q;
    logic [15:0]    r_grant;
    logic [WB-1:0]  r_scan_v;
    logic [IB-1:0]  r_scan_i;

    // memory op issued by decide / scan
    logic           dq_we, dq_re, p_we, p_re;
    logic [WB+DB-1:0] dq_addr;
    logic [PB-1:0]  p_addr;

    logic has_dq;
    logic [WB-1:0] w_idx;
    assign has_dq = (XB'(r_worker) < XB'(NUM_WORKERS));
    assign w_idx  = WB'(r_worker);

    function automatic logic [DB-1:0] dwrap(input logic [DB-1:0] a, input logic [DCB-1:0] b);
        logic [DCB:0] s;
        s = {{(DCB-DB+1){1'b0}}, a} + {1'b0, b};
        if (s > (DCB+1)'(DD_M1)) s = s - (DCB+1)'(DEQUE_DEPTH);
        return s[DB-1:0];
    endfunction

    function automatic logic [PB-1:0] pwrap(input logic [PB-1:0] a, input logic [PCB-1:0] b);
        logic [PCB:0] s;
        s = {{(PCB-PB+1){1'b0}}, a} + {1'b0, b};
        if (s > (PCB+1)'(PD_M1)) s = s - (PCB+1)'(POOL_DEPTH);
        return s[PB-1:0];
    endfunction

    logic [DB-1:0] own_tail, sc_slot;
    assign own_tail = dwrap(r_head[w_idx], r_cnt[w_idx]);
    assign sc_slot  = dwrap(r_head[r_scan_v], r_cnt[r_scan_v] - DCB'(1));

    logic own_full, own_empty, pool_full, pool_empty, sc_skip, sc_hit, sc_last;
    assign own_full   = (r_cnt[w_idx] == DCB'(DEQUE_DEPTH));
    assign own_empty  = (r_cnt[w_idx] == '0);
    assign pool_full  = (r_pcnt == PCB'(POOL_DEPTH));
    assign pool_empty = (r_pcnt == '0);
    assign sc_skip    = has_dq && (r_scan_v == w_idx);
    assign sc_hit     = !sc_skip && (r_cnt[r_scan_v] != '0);
    assign sc_last    = (r_scan_i == IB'(NW_M1));

    assign o_stat.need_scan = r_kind && !(has_dq && !own_empty) && pool_empty;
    assign o_stat.scan_done = sc_hit || sc_last;

    always_comb begin
        dq_we = 1'b0; dq_re = 1'b0; p_we = 1'b0; p_re = 1'b0;
        dq_addr = {w_idx, own_tail};
        p_addr  = pwrap(r_phead, r_pcnt);
        if (i_cmd.decide) begin
            if (!r_kind) begin
                if (r_from && has_dq) dq_we = !own_full;
                else                  p_we  = !pool_full;
            end else if (has_dq && !own_empty) begin
                dq_re = 1'b1;
                dq_addr = {w_idx, r_head[w_idx]};
            end else if (!pool_empty) begin
                p_re = 1'b1;
                p_addr = r_phead;
            end
        end else if (i_cmd.scan_step && sc_hit) begin
            dq_re = 1'b1;
            dq_addr = {r_scan_v, sc_slot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (dq_we) r_dq_mem[dq_addr] <= r_task;
        if (dq_re) r_dq_q <= r_dq_mem[dq_addr];
        if (p_we)  r_pool_mem[p_addr] <= r_task;
        if (p_re)  r_pool_q <= r_pool_mem[p_addr];
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORKERS; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
            end
            r_phead <= '0;
            r_pcnt  <= '0;
        end else begin
            if (dq_we) r_cnt[w_idx] <= r_cnt[w_idx] + DCB'(1);
            if (p_we)  r_pcnt <= r_pcnt + PCB'(1);
            if (i_cmd.decide && dq_re) begin
                r_head[w_idx] <= dwrap(r_head[w_idx], DCB'(1));
                r_cnt[w_idx]  <= r_cnt[w_idx] - DCB'(1);
            end
            if (p_re) begin
                r_phead <= pwrap(r_phead, PCB'(1));
                r_pcnt  <= r_pcnt - PCB'(1);
            end
            if (i_cmd.scan_step && sc_hit) r_cnt[r_scan_v] <= r_cnt[r_scan_v] - DCB'(1);
        end
    end

    // item, scan and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_worker <= i_worker;
            r_from   <= i_from_worker;
            r_task   <= TASK_BITS'(i_task_id);
        end
        if (i_cmd.decide) begin
            r_rd_dq   <= dq_re;
            r_rd_pool <= p_re;
            r_scan_i  <= '0;
            if (has_dq) r_scan_v <= (w_idx == WB'(NW_M1)) ? '0 : w_idx + WB'(1);
            else        r_scan_v <= '0;
            r_victim <= '0;
            if (!r_kind) begin
                r_source <= wstd_pkg::SRC_OWN;
                r_status <= (dq_we || p_we) ? wstd_pkg::ST_OK : wstd_pkg::ST_FULL;
            end else begin
                r_status <= wstd_pkg::ST_OK;
                r_source <= dq_re ? wstd_pkg::SRC_OWN : wstd_pkg::SRC_POOL;
            end
        end
        if (i_cmd.scan_step) begin
            if (sc_hit) begin
                r_rd_dq  <= 1'b1;
                r_source <= wstd_pkg::SRC_STEAL;
                r_victim <= 3'(r_scan_v);
            end else if (sc_last) begin
                r_source <= wstd_pkg::SRC_OWN;
                r_status <= wstd_pkg::ST_NONE;
            end
            r_scan_v <= (r_scan_v == WB'(NW_M1)) ? '0 : r_scan_v + WB'(1);
            r_scan_i <= r_scan_i + IB'(1);
        end
        if (i_cmd.finish) begin
            if (r_rd_dq)        r_grant <= 16'(r_dq_q);
            else if (r_rd_pool) r_grant <= 16'(r_pool_q);
            else                r_grant <= '0;
        end
    end

    assign o_status       = r_status;
    assign o_granted_task = r_grant;
    assign o_source       = r_source;
    assign o_victim       = r_victim;
endmodule

@@ hw/rtl/work_stealing_task_dispatcher.sv @@
// Top level of the work-stealing task dispatcher.
//   channel | direction | handshake            | payload
//   input   | in        | i_valid / o_ready    | kind, worker, from_worker, task_id
//   result  | out       | o_valid / i_ready    | status, granted_task, source, victim
// Submit and hit on own deque or pool: per item the states are load, decide, read, result.
// Steal: a scan step walks candidates between decide and read, at most NUM_WORKERS of them.
// Reset empties every deque and the pool through the counters; memories are not cleared.
// A result waits in its registers until taken; no new beat is accepted meanwhile.
module work_stealing_task_dispatcher #(
    parameter int NUM_WORKERS = 8,
    parameter int DEQUE_DEPTH = 16,
    parameter int POOL_DEPTH  = 32,
    parameter int TASK_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [2:0]  i_worker,
    input  logic        i_from_worker,
    input  logic [15:0] i_task_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_task,
    output logic [1:0]  o_source,
    output logic [2:0]  o_victim
);
    wstd_pkg::t_cmd  cmd;
    wstd_pkg::t_stat stat;

    wstd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_stat(stat), .o_cmd(cmd)
    );

    wstd_dp #(
        .NUM_WORKERS(NUM_WORKERS), .DEQUE_DEPTH(DEQUE_DEPTH),
        .POOL_DEPTH(POOL_DEPTH), .TASK_BITS(TASK_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_kind(i_kind), .i_worker(i_worker), .i_from_worker(i_from_worker),
        .i_task_id(i_task_id), .o_status(o_status), .o_granted_task(o_granted_task),
        .o_source(o_source), .o_victim(o_victim)
    );

`ifndef SYNTH
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("accept not followed by busy");
    a_steal_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_source != wstd_pkg::SRC_STEAL) |-> (o_victim == 3'd0))
        else $error("victim set without steal");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != wstd_pkg::ST_OK) |-> (o_granted_task == 16'd0))
        else $error("task on a non-grant");
`endif
endmodule

@@ sim/work_stealing_task_dispatcher_tb.sv @@
// Testbench for the work-stealing task dispatcher: random and directed beats, queue-model scoreboard.
module work_stealing_task_dispatcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = 8;
    localparam int DD = 16;
    localparam int PD = 32;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] task_id;
        logic [1:0]  source;
        logic [2:0]  victim;
    } t_grant;

    int n_errors = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Dispatcher model: worker deques, the pool, and expected grants in order.
    class dispatch_scoreboard;
        logic [15:0] deq[NW][$];
        logic [15:0] pool[$];
        t_grant grants_due[$];

        function void note_beat(logic kind, logic [2:0] w, logic fw, logic [15:0] tid);
            t_grant g;
            int v;
            g = '0;
            g.status = wstd_pkg::ST_OK;
            g.source = wstd_pkg::SRC_OWN;
            if (kind == 1'b0) begin
                if (fw) begin
                    if (deq[w].size() >= DD) g.status = wstd_pkg::ST_FULL;
                    else deq[w] = {deq[w], tid};
                end else begin
                    if (pool.size() >= PD) g.status = wstd_pkg::ST_FULL;
                    else pool = {pool, tid};
                end
            end else if (deq[w].size() != 0) begin
                g.task_id = deq[w][0];
                deq[w].delete(0);
            end else if (pool.size() != 0) begin
                g.task_id = pool[0];
                pool.delete(0);
                g.source = wstd_pkg::SRC_POOL;
            end else begin
                g.status = wstd_pkg::ST_NONE;
                for (int i = 1; i < NW; i++) begin
                    v = (w + i) % NW;
                    if (deq[v].size() != 0) begin
                        g.status = wstd_pkg::ST_OK;
                        g.task_id = deq[v][$];
                        deq[v].delete(deq[v].size() - 1);
                        g.source = wstd_pkg::SRC_STEAL;
                        g.victim = v[2:0];
                        break;
                    end
                end
            end
            grants_due = {grants_due, g};
        endfunction

        task check_result(t_grant got);
            t_grant want;
            if (grants_due.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                want = grants_due[0];
                grants_due.delete(0);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.task_id !== want.task_id)
                    report_mismatch("granted_task", got.task_id, want.task_id);
                if (got.source !== want.source)
                    report_mismatch("source", got.source, want.source);
                if (got.victim !== want.victim)
                    report_mismatch("victim", got.victim, want.victim);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = 1'b0;
    logic [2:0]  i_worker = '0;
    logic        i_from_worker = 1'b0;
    logic [15:0] i_task_id = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_granted_task;
    logic [1:0]  o_source;
    logic [2:0]  o_victim;

    int  send_idle_pct = 38;
    int  recv_idle_pct = 56;
    bit  recv_hold = 1'b0;
    bit  stim_done = 1'b0;
    int  quiet_cycles = 0;
    dispatch_scoreboard sb = new();

    always #2 i_clk = ~i_clk;

    work_stealing_task_dispatcher u_top (.*);

    // Receiver: random ready, checking each accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{o_status, o_granted_task, o_source, o_victim});
        i_ready <= i_rst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Valid stays up from one beat to the next unless the sender idles.
    task automatic send_beat(logic kind, logic [2:0] w, logic fw, logic [15:0] tid);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_worker <= w;
        i_from_worker <= fw;
        i_task_id <= tid;
        do @(posedge i_clk); while (!o_ready);
        sb.note_beat(kind, w, fw, tid);
    endtask

    task automatic random_beat();
        int r;
        r = $urandom_range(99);
        // Lean toward worker submits so deques fill and steals happen.
        if (r < 35) send_beat(1'b0, 3'($urandom_range(7)), 1'b1, 16'($urandom));
        else if (r < 50) send_beat(1'b0, 3'($urandom_range(7)), 1'b0, 16'($urandom));
        else send_beat(1'b1, 3'($urandom_range(7)), 1'($urandom_range(1)), 16'($urandom));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty request, extremes, fill/overflow, own/pool/steal.
        send_beat(1'b1, 3'd0, 1'b0, 16'hffff);
        send_beat(1'b0, 3'd7, 1'b1, 16'hffff);
        send_beat(1'b0, 3'd7, 1'b1, 16'h0000);
        send_beat(1'b1, 3'd7, 1'b1, 16'h1234);
        send_beat(1'b0, 3'd0, 1'b0, 16'haaaa);
        send_beat(1'b1, 3'd7, 1'b0, 16'h5555);
        send_beat(1'b1, 3'd0, 1'b0, 16'h0);
        send_beat(1'b1, 3'd3, 1'b0, 16'h0);
        for (int i = 0; i < DD + 1; i++) send_beat(1'b0, 3'd2, 1'b1, 16'(16'h100 + i));
        send_beat(1'b1, 3'd1, 1'b0, 16'h0);

        // Overflow the pool; the receiver is held off at first, so the dispatcher stalls on a result.
        recv_hold = 1'b1;
        fork
            begin
                for (int i = 0; i < PD + 2; i++)
                    send_beat(1'b0, 3'($urandom_range(7)), 1'b0, 16'($urandom));
            end
            repeat (300) @(posedge i_clk);
        join_any
        recv_hold = 1'b0;
        wait fork;

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 38 : (p == 1) ? 56 : 0;
            recv_idle_pct = (p == 0) ? 56 : (p == 1) ? 38 : 0;
            for (int i = 0; i < 520; i++) random_beat();
        end
        // Drain what remains so all deques end empty.
        repeat (200) send_beat(1'b1, 3'($urandom_range(7)), 1'b0, 16'h0);
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (sb.grants_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
